// File: rtl/strided_cube_occupancy_count_unit_assert.svh
// Assertion macros for the strided cube occupancy count unit
`ifndef STRIDED_CUBE_OCCUPANCY_COUNT_UNIT_ASSERT_SVH
`define STRIDED_CUBE_OCCUPANCY_COUNT_UNIT_ASSERT_SVH

// same-cycle implication, sampled on clk, quiet in reset
`define SCOC_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("scoc: property failed");

// next-cycle implication, sampled on clk, quiet in reset
`define SCOC_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("scoc: property failed");

`endif

// File: rtl/scoc_pkg.sv
// Shared types, codes and constants of the strided cube occupancy count unit
package scoc_pkg;

	localparam int CFG_W     = 11;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_NUM   = 5;
	localparam int NUM_W     = 24;
	localparam int COORD_W   = 10;
	localparam int COUNT_W   = 31;
	localparam int AXES      = 3;

	localparam logic [CFG_IDX_W-1:0] CFG_SIZE_X = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SIZE_Y = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SIZE_Z = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_EDGE   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_STRIDE = 3'd4;

	localparam logic [CFG_W-1:0] CFG_RESET [CFG_NUM] = '{
		11'd64, 11'd64, 11'd64, 11'd8, 11'd8
	};

	typedef enum logic [2:0] {
		FR_IDLE,
		FR_DIV,
		FR_MUL1,
		FR_MUL2,
		FR_PUSH
	} front_state_t;

	typedef enum logic [1:0] {
		DK_N,
		DK_H,
		DK_L
	} div_kind_t;

	typedef enum logic [2:0] {
		BK_CLR,
		BK_IDLE,
		BK_RD,
		BK_WR,
		BK_ZERO,
		BK_ORD,
		BK_OLD
	} back_state_t;

	function automatic int ent_w(int cw);
		return 3 + 3 * cw + 2 * NUM_W + 3 * COORD_W;
	endfunction

endpackage

// File: rtl/scoc_in_if.sv
// Voxel input channel
interface scoc_in_if;
	logic valid;
	logic ready;
	logic occupied;

	modport source (output valid, output occupied, input ready);
	modport sink (input valid, input occupied, output ready);
endinterface

// File: rtl/scoc_out_if.sv
// Cube result channel
interface scoc_out_if import scoc_pkg::*;;
	logic               valid;
	logic               ready;
	logic [NUM_W-1:0]   cube_number;
	logic [COORD_W-1:0] start_z;
	logic [COORD_W-1:0] start_y;
	logic [COORD_W-1:0] start_x;
	logic [COUNT_W-1:0] set_count;

	modport source (output valid, output cube_number, output start_z, output start_y,
		output start_x, output set_count, input ready);
	modport sink (input valid, input cube_number, input start_z, input start_y,
		input start_x, input set_count, output ready);
endinterface

// File: rtl/strided_cube_occupancy_count_unit.sv
// Top level of the strided cube occupancy count unit
// Voxels enter in raster order, x fastest. The front takes a voxel that touches no tally
// through accept and classify, and any other voxel through accept, two multiply stages for
// the cube number and a hand-off into a four-word queue that waits while the queue is full.
// The back pops each word, then spends a memory read and a write for each cube covering a
// set voxel, up to ceil(cube_edge/stride) cubes per axis, one write to zero a cube opened by
// a clear voxel, and a read and a result-register load, which waits for a free result slot,
// to read out a finishing cube. After reset the tally memory is cleared address by address,
// and after any configuration write the unit runs nine serial divisions by the stride; no
// voxel is taken during either. TALLY_DEPTH must be a power of two.
module strided_cube_occupancy_count_unit import scoc_pkg::*; #(
	parameter int MAX_EXTENT  = 1024,
	parameter int TALLY_DEPTH = 4096
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	scoc_in_if.sink              in_ch,
	scoc_out_if.source           out_ch
);
	localparam int EW    = $clog2(MAX_EXTENT + 1);
	localparam int ENT_W = ent_w($clog2(MAX_EXTENT));

	logic             push_valid, push_ready, pop_valid, pop_ready, clr_busy;
	logic [ENT_W-1:0] push_data, pop_data;
	logic [EW-1:0]    nx;
	logic [NUM_W-1:0] nxy;

	scoc_front #(.MAX_EXTENT(MAX_EXTENT)) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_ch      (in_ch),
		.clr_busy   (clr_busy),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data),
		.nx         (nx),
		.nxy        (nxy)
	);

	scoc_queue #(.WIDTH(ENT_W)) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_data)
	);

	scoc_back #(.MAX_EXTENT(MAX_EXTENT), .TALLY_DEPTH(TALLY_DEPTH)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_data  (pop_data),
		.nx        (nx),
		.nxy       (nxy),
		.clr_busy  (clr_busy),
		.out_ch    (out_ch)
	);
endmodule

// File: rtl/scoc_queue.sv
// Four-word queue between front and back
module scoc_queue #(
	parameter int WIDTH = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push_valid,
	output logic             push_ready,
	input  logic [WIDTH-1:0] push_data,
	output logic             pop_valid,
	input  logic             pop_ready,
	output logic [WIDTH-1:0] pop_data
);
	localparam int DEPTH = 4;
	localparam int PW    = $clog2(DEPTH);

	logic [WIDTH-1:0] slot_q [DEPTH];
	logic [PW-1:0]    wp_q, rp_q;
	logic [PW:0]      cnt_q;
	logic             push, pop;

	assign push_ready = cnt_q != (PW+1)'(DEPTH);
	assign pop_valid  = cnt_q != '0;
	assign pop_data   = slot_q[rp_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= wp_q + PW'(1);
			if (pop) rp_q <= rp_q + PW'(1);
			if (push && !pop) cnt_q <= cnt_q + (PW+1)'(1);
			else if (pop && !push) cnt_q <= cnt_q - (PW+1)'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (push) slot_q[wp_q] <= push_data;
	end
endmodule

// File: rtl/scoc_front.sv
// Front end: configuration, cursors, cube classification and cube numbering
module scoc_front import scoc_pkg::*; #(
	parameter int MAX_EXTENT = 1024
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [CFG_IDX_W-1:0]                 cfg_index,
	input  logic [CFG_W-1:0]                     cfg_data,
	scoc_in_if.sink                              in_ch,
	input  logic                                 clr_busy,
	output logic                                 push_valid,
	input  logic                                 push_ready,
	output logic [ent_w($clog2(MAX_EXTENT))-1:0] push_data,
	output logic [$clog2(MAX_EXTENT+1)-1:0]      nx,
	output logic [NUM_W-1:0]                     nxy
);
	localparam int EW   = $clog2(MAX_EXTENT + 1);
	localparam int CW   = $clog2(MAX_EXTENT);
	localparam int XW   = (CFG_W > EW ? CFG_W : EW) + 1;
	localparam int TW   = EW + 2;
	localparam int CNTW = $clog2(EW + 1);

	typedef struct packed {
		logic               occ;
		logic               open3;
		logic               close3;
		logic [CW-1:0]      span_z;
		logic [CW-1:0]      span_y;
		logic [CW-1:0]      span_x;
		logic [NUM_W-1:0]   num_lo;
		logic [NUM_W-1:0]   num_hi;
		logic [COORD_W-1:0] st_z;
		logic [COORD_W-1:0] st_y;
		logic [COORD_W-1:0] st_x;
	} ent_t;

	front_state_t state_q, state_d;

	logic [CFG_W-1:0] cfg_q [CFG_NUM];
	logic [EW-1:0]    eff_v [CFG_NUM];
	logic [EW-1:0]    sz [AXES];
	logic [EW-1:0]    e, s;

	logic [CW-1:0] c_q [AXES];
	logic [CW-1:0] qh_q [AXES];
	logic [CW-1:0] rh_q [AXES];
	logic [CW-1:0] ql_q [AXES];
	logic [CW-1:0] rl_q [AXES];
	logic [EW-1:0] n_q [AXES];

	logic signed [TW-1:0] t_a [AXES];
	logic [EW-1:0]        nm1 [AXES];
	logic [CW-1:0]        hi_a [AXES];
	logic [CW-1:0]        lo_a [AXES];
	logic [AXES-1:0]      tpos, clamp, covered, opens, closes, wrap, h_roll, l_roll, size_ge;
	logic [AXES-1:0]      adv;
	logic                 acc;

	logic [1:0]      div_axis_q;
	div_kind_t       div_kind_q;
	logic [CNTW-1:0] div_cnt_q;
	logic            dirty_q;
	logic [EW-1:0]   div_num_q, div_quo_q, quo_nx, dividend;
	logic [EW:0]     div_rem_q, rem_sh, rem_nx;
	logic            div_ge, div_run, div_fin, last_op, div_done;

	logic               occ_s1, open3_s1, close3_s1, skip_s1;
	logic [CW-1:0]      lo_s1 [AXES];
	logic [CW-1:0]      hi_s1 [AXES];
	logic [NUM_W-1:0]   m1_s2, h1_s2, m2_s3, h2_s3;
	logic [COORD_W-1:0] st_s2 [AXES];
	ent_t               ent;

	always_comb begin
		for (int i = 0; i < CFG_NUM; i++) begin
			if (cfg_q[i] == '0) eff_v[i] = EW'(1);
			else if (XW'(cfg_q[i]) > XW'(MAX_EXTENT)) eff_v[i] = EW'(MAX_EXTENT);
			else eff_v[i] = EW'(cfg_q[i]);
		end
		for (int a = 0; a < AXES; a++) sz[a] = eff_v[a];
		e = eff_v[CFG_EDGE];
		s = eff_v[CFG_STRIDE];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CFG_NUM; i++) cfg_q[i] <= CFG_RESET[i];
		end else if (cfg_we && cfg_index < CFG_IDX_W'(CFG_NUM)) begin
			cfg_q[cfg_index] <= cfg_data;
		end
	end

	always_comb begin
		for (int a = 0; a < AXES; a++) begin
			t_a[a] = $signed({{(TW-CW){1'b0}}, c_q[a]}) - $signed({{(TW-EW){1'b0}}, e});
			tpos[a] = !t_a[a][TW-1];
			nm1[a] = n_q[a] - EW'(1);
			clamp[a] = (n_q[a] != '0) && (EW'(qh_q[a]) > nm1[a]);
			hi_a[a] = clamp[a] ? CW'(nm1[a]) : qh_q[a];
			lo_a[a] = tpos[a] ? ql_q[a] + CW'(1) : '0;
			covered[a] = (n_q[a] != '0) && (lo_a[a] <= hi_a[a]);
			opens[a] = covered[a] && !clamp[a] && (rh_q[a] == '0);
			closes[a] = covered[a] && (tpos[a] ? (EW'(rl_q[a]) == s - EW'(1)) : (&t_a[a]));
			wrap[a] = ((EW+1)'(c_q[a]) + (EW+1)'(1)) >= (EW+1)'(sz[a]);
			h_roll[a] = (EW'(rh_q[a]) + EW'(1)) == s;
			l_roll[a] = (EW'(rl_q[a]) + EW'(1)) == s;
			size_ge[a] = sz[a] >= e;
		end
		adv = {wrap[0] && wrap[1], wrap[0], 1'b1};
	end

	assign acc = in_ch.valid && in_ch.ready;

	// serial restoring divider by the stride
	assign div_run  = state_q == FR_DIV;
	assign div_fin  = div_run && !cfg_we && (div_cnt_q == CNTW'(EW));
	assign last_op  = (div_axis_q == 2'd2) && (div_kind_q == DK_L);
	assign div_done = div_fin && last_op;
	assign rem_sh   = {div_rem_q[EW-1:0], div_num_q[EW-1]};
	assign div_ge   = rem_sh >= {1'b0, s};
	assign rem_nx   = div_ge ? rem_sh - {1'b0, s} : rem_sh;
	assign quo_nx   = {div_quo_q[EW-2:0], div_ge};

	always_comb begin
		unique case (div_kind_q)
			DK_N:    dividend = size_ge[div_axis_q] ? sz[div_axis_q] - e : '0;
			DK_H:    dividend = EW'(c_q[div_axis_q]);
			DK_L:    dividend = tpos[div_axis_q] ? t_a[div_axis_q][EW-1:0] : '0;
			default: dividend = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_axis_q <= '0;
			div_kind_q <= DK_N;
			div_cnt_q  <= '0;
			dirty_q    <= 1'b1;
		end else if (cfg_we) begin
			div_axis_q <= '0;
			div_kind_q <= DK_N;
			div_cnt_q  <= '0;
			dirty_q    <= 1'b1;
		end else if (div_run) begin
			if (div_cnt_q == CNTW'(EW)) begin
				div_cnt_q <= '0;
				if (last_op) begin
					div_axis_q <= '0;
					div_kind_q <= DK_N;
					dirty_q    <= 1'b0;
				end else begin
					unique case (div_kind_q)
						DK_N: div_kind_q <= DK_H;
						DK_H: div_kind_q <= DK_L;
						default: begin
							div_kind_q <= DK_N;
							div_axis_q <= div_axis_q + 2'd1;
						end
					endcase
				end
			end else begin
				div_cnt_q <= div_cnt_q + CNTW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (div_run) begin
			if (div_cnt_q == '0) begin
				div_num_q <= dividend;
				div_rem_q <= '0;
				div_quo_q <= '0;
			end else begin
				div_num_q <= {div_num_q[EW-2:0], 1'b0};
				div_rem_q <= rem_nx;
				div_quo_q <= quo_nx;
			end
		end
	end

	// cursors with running quotient and remainder by the stride
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int a = 0; a < AXES; a++) begin
				c_q[a]  <= '0;
				qh_q[a] <= '0;
				rh_q[a] <= '0;
				ql_q[a] <= '0;
				rl_q[a] <= '0;
				n_q[a]  <= '0;
			end
		end else begin
			if (acc) begin
				for (int a = 0; a < AXES; a++) begin
					if (adv[a]) begin
						if (wrap[a]) begin
							c_q[a]  <= '0;
							qh_q[a] <= '0;
							rh_q[a] <= '0;
							ql_q[a] <= '0;
							rl_q[a] <= '0;
						end else begin
							c_q[a] <= c_q[a] + CW'(1);
							if (h_roll[a]) begin
								rh_q[a] <= '0;
								qh_q[a] <= qh_q[a] + CW'(1);
							end else begin
								rh_q[a] <= rh_q[a] + CW'(1);
							end
							if (tpos[a]) begin
								if (l_roll[a]) begin
									rl_q[a] <= '0;
									ql_q[a] <= ql_q[a] + CW'(1);
								end else begin
									rl_q[a] <= rl_q[a] + CW'(1);
								end
							end
						end
					end
				end
			end
			if (div_fin) begin
				unique case (div_kind_q)
					DK_N: n_q[div_axis_q] <= size_ge[div_axis_q] ? quo_nx + EW'(1) : '0;
					DK_H: begin
						qh_q[div_axis_q] <= CW'(quo_nx);
						rh_q[div_axis_q] <= CW'(rem_nx);
					end
					default: begin
						ql_q[div_axis_q] <= CW'(quo_nx);
						rl_q[div_axis_q] <= CW'(rem_nx);
					end
				endcase
			end
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			FR_IDLE: begin
				if (dirty_q) state_d = FR_DIV;
				else if (acc) state_d = FR_MUL1;
			end
			FR_DIV:  if (div_done) state_d = FR_IDLE;
			FR_MUL1: state_d = skip_s1 ? FR_IDLE : FR_MUL2;
			FR_MUL2: state_d = FR_PUSH;
			FR_PUSH: if (push_ready) state_d = FR_IDLE;
			default: state_d = FR_IDLE;
		endcase
	end

	always_comb begin
		in_ch.ready = (state_q == FR_IDLE) && !dirty_q && !clr_busy;
		push_valid  = state_q == FR_PUSH;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= FR_IDLE;
		else state_q <= state_d;
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			occ_s1    <= in_ch.occupied;
			open3_s1  <= &opens;
			close3_s1 <= &closes;
			skip_s1   <= !(&covered) || (!in_ch.occupied && !(&opens) && !(&closes));
			for (int a = 0; a < AXES; a++) begin
				lo_s1[a] <= lo_a[a];
				hi_s1[a] <= hi_a[a];
			end
		end
		if (state_q == FR_MUL1) begin
			m1_s2 <= NUM_W'(lo_s1[2]) * NUM_W'(n_q[1]);
			h1_s2 <= NUM_W'(hi_s1[2]) * NUM_W'(n_q[1]);
			for (int a = 0; a < AXES; a++) st_s2[a] <= COORD_W'(lo_s1[a]) * COORD_W'(s);
		end
		if (state_q == FR_MUL2) begin
			m2_s3 <= (m1_s2 + NUM_W'(lo_s1[1])) * NUM_W'(n_q[0]);
			h2_s3 <= (h1_s2 + NUM_W'(hi_s1[1])) * NUM_W'(n_q[0]);
		end
		nxy <= NUM_W'(n_q[0]) * NUM_W'(n_q[1]);
	end

	always_comb begin
		ent.occ    = occ_s1;
		ent.open3  = open3_s1;
		ent.close3 = close3_s1;
		ent.span_z = hi_s1[2] - lo_s1[2];
		ent.span_y = hi_s1[1] - lo_s1[1];
		ent.span_x = hi_s1[0] - lo_s1[0];
		ent.num_lo = m2_s3 + NUM_W'(lo_s1[0]);
		ent.num_hi = h2_s3 + NUM_W'(hi_s1[0]);
		ent.st_z   = st_s2[2];
		ent.st_y   = st_s2[1];
		ent.st_x   = st_s2[0];
	end

	assign push_data = ent;
	assign nx        = n_q[0];
endmodule

// File: rtl/scoc_back.sv
// Back end: tally memory updates, clearing pass and result register
module scoc_back import scoc_pkg::*; #(
	parameter int MAX_EXTENT  = 1024,
	parameter int TALLY_DEPTH = 4096
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 pop_valid,
	output logic                                 pop_ready,
	input  logic [ent_w($clog2(MAX_EXTENT))-1:0] pop_data,
	input  logic [$clog2(MAX_EXTENT+1)-1:0]      nx,
	input  logic [NUM_W-1:0]                     nxy,
	output logic                                 clr_busy,
	scoc_out_if.source                           out_ch
);
	localparam int CW = $clog2(MAX_EXTENT);
	localparam int AW = $clog2(TALLY_DEPTH);

	typedef struct packed {
		logic               occ;
		logic               open3;
		logic               close3;
		logic [CW-1:0]      span_z;
		logic [CW-1:0]      span_y;
		logic [CW-1:0]      span_x;
		logic [NUM_W-1:0]   num_lo;
		logic [NUM_W-1:0]   num_hi;
		logic [COORD_W-1:0] st_z;
		logic [COORD_W-1:0] st_y;
		logic [COORD_W-1:0] st_x;
	} ent_t;

	back_state_t state_q, state_d;

	logic [COUNT_W-1:0] tally_mem [TALLY_DEPTH];
	logic [COUNT_W-1:0] rd_q, wdata;
	logic [AW-1:0]      waddr, raddr, clr_q;
	logic               we, re;

	ent_t             pe, cur_q;
	logic [CW-1:0]    jx_q, jy_q, jz_q;
	logic [NUM_W-1:0] num_q, row_q, plane_q;
	logic             last, slot_free, load;

	logic               o_valid_q;
	logic [NUM_W-1:0]   o_num_q;
	logic [COORD_W-1:0] o_z_q, o_y_q, o_x_q;
	logic [COUNT_W-1:0] o_cnt_q;

	assign pe        = ent_t'(pop_data);
	assign last      = (jx_q == cur_q.span_x) && (jy_q == cur_q.span_y) &&
		(jz_q == cur_q.span_z);
	assign slot_free = !o_valid_q || out_ch.ready;
	assign load      = (state_q == BK_OLD) && slot_free;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			BK_CLR:  if (clr_q == AW'(TALLY_DEPTH - 1)) state_d = BK_IDLE;
			BK_IDLE: begin
				if (pop_valid) begin
					if (pe.occ) state_d = BK_RD;
					else if (pe.open3) state_d = BK_ZERO;
					else state_d = BK_ORD;
				end
			end
			BK_RD:   state_d = BK_WR;
			BK_WR:   if (last) state_d = cur_q.close3 ? BK_ORD : BK_IDLE;
				else state_d = BK_RD;
			BK_ZERO: state_d = cur_q.close3 ? BK_ORD : BK_IDLE;
			BK_ORD:  state_d = BK_OLD;
			BK_OLD:  if (slot_free) state_d = BK_IDLE;
			default: state_d = BK_IDLE;
		endcase
	end

	always_comb begin
		we        = 1'b0;
		re        = 1'b0;
		waddr     = num_q[AW-1:0];
		raddr     = num_q[AW-1:0];
		wdata     = '0;
		pop_ready = 1'b0;
		unique case (state_q)
			BK_CLR: begin
				we    = 1'b1;
				waddr = clr_q;
			end
			BK_IDLE: pop_ready = 1'b1;
			BK_RD:   re = 1'b1;
			BK_WR: begin
				we    = 1'b1;
				wdata = (last && cur_q.open3) ? COUNT_W'(1) : rd_q + COUNT_W'(1);
			end
			BK_ZERO: begin
				we    = 1'b1;
				waddr = cur_q.num_hi[AW-1:0];
			end
			BK_ORD: begin
				re    = 1'b1;
				raddr = cur_q.num_lo[AW-1:0];
			end
			default: ;
		endcase
	end

	assign clr_busy = state_q == BK_CLR;

	always_ff @(posedge clk) begin
		if (we) tally_mem[waddr] <= wdata;
		if (re) rd_q <= tally_mem[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= BK_CLR;
			clr_q     <= '0;
			o_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == BK_CLR) clr_q <= clr_q + AW'(1);
			if (load) o_valid_q <= 1'b1;
			else if (out_ch.ready) o_valid_q <= 1'b0;
		end
	end

	// walk covering cubes: x innermost, then y, then z
	always_ff @(posedge clk) begin
		if (state_q == BK_IDLE && pop_valid) begin
			cur_q   <= pe;
			num_q   <= pe.num_lo;
			row_q   <= pe.num_lo;
			plane_q <= pe.num_lo;
			jx_q    <= '0;
			jy_q    <= '0;
			jz_q    <= '0;
		end else if (state_q == BK_WR && !last) begin
			if (jx_q != cur_q.span_x) begin
				jx_q  <= jx_q + CW'(1);
				num_q <= num_q + NUM_W'(1);
			end else if (jy_q != cur_q.span_y) begin
				jx_q  <= '0;
				jy_q  <= jy_q + CW'(1);
				row_q <= row_q + NUM_W'(nx);
				num_q <= row_q + NUM_W'(nx);
			end else begin
				jx_q    <= '0;
				jy_q    <= '0;
				jz_q    <= jz_q + CW'(1);
				plane_q <= plane_q + nxy;
				row_q   <= plane_q + nxy;
				num_q   <= plane_q + nxy;
			end
		end
		if (load) begin
			o_num_q <= cur_q.num_lo;
			o_z_q   <= cur_q.st_z;
			o_y_q   <= cur_q.st_y;
			o_x_q   <= cur_q.st_x;
			o_cnt_q <= rd_q;
		end
	end

	assign out_ch.valid       = o_valid_q;
	assign out_ch.cube_number = o_num_q;
	assign out_ch.start_z     = o_z_q;
	assign out_ch.start_y     = o_y_q;
	assign out_ch.start_x     = o_x_q;
	assign out_ch.set_count   = o_cnt_q;
endmodule

// File: rtl/scoc_checker.sv
// Port-level checks of the strided cube occupancy count unit, with their binding
`include "strided_cube_occupancy_count_unit_assert.svh"

module scoc_checker import scoc_pkg::*; (
	input logic               clk,
	input logic               arst_n,
	input logic               cfg_we,
	input logic               in_valid,
	input logic               in_ready,
	input logic               out_valid,
	input logic               out_ready,
	input logic [NUM_W-1:0]   cube_number,
	input logic [COUNT_W-1:0] set_count
);
	`SCOC_ASSERT_NEXT(a_one_voxel_at_a_time, in_valid && in_ready, !in_ready)
	`SCOC_ASSERT_NEXT(a_cfg_blocks_input, cfg_we, !in_ready)
	`SCOC_ASSERT_NEXT(a_result_held, out_valid && !out_ready,
		out_valid && $stable(cube_number) && $stable(set_count))
	`SCOC_ASSERT_IMP(a_clear_after_reset, $rose(arst_n), !in_ready)
endmodule

bind strided_cube_occupancy_count_unit scoc_checker u_scoc_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.cfg_we      (cfg_we),
	.in_valid    (in_ch.valid),
	.in_ready    (in_ch.ready),
	.out_valid   (out_ch.valid),
	.out_ready   (out_ch.ready),
	.cube_number (out_ch.cube_number),
	.set_count   (out_ch.set_count)
);

// File: dv/scoc_cube_checker.sv
// Cube tally predictor and result scoreboard for the strided cube occupancy count unit
module scoc_cube_checker import scoc_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	scoc_in_if                   in_ch,
	scoc_out_if                  out_ch,
	output int                   fail_count,
	output int                   cubes_pending,
	output int                   cubes_seen
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam longint unsigned EXTENT_MAX = 1024;
	localparam int              TALLY_N    = 4096;

	typedef struct {
		longint unsigned n;
		longint unsigned lo;
		longint unsigned hi;
		bit              covered;
		bit              opens;
		bit              closes;
	} axis_span_t;

	typedef struct {
		logic [NUM_W-1:0]   cube_number;
		logic [COORD_W-1:0] start_z;
		logic [COORD_W-1:0] start_y;
		logic [COORD_W-1:0] start_x;
		logic [COUNT_W-1:0] set_count;
	} cube_word_t;

	logic [CFG_W-1:0]   reg_val [CFG_NUM];
	int unsigned        cur_x, cur_y, cur_z;
	logic [COUNT_W-1:0] tally [TALLY_N];
	cube_word_t         cube_q [$];

	function automatic longint unsigned clamp_reg(logic [CFG_W-1:0] v);
		if (v == 0) return 1;
		if (v > EXTENT_MAX) return EXTENT_MAX;
		return v;
	endfunction

	function automatic axis_span_t span_of(longint unsigned sz, longint unsigned e,
			longint unsigned s, longint unsigned c);
		axis_span_t a;
		a.n = (sz >= e) ? (sz - e) / s + 1 : 0;
		a.lo = (c >= e) ? (c - e) / s + 1 : 0;
		a.hi = c / s;
		if (a.n > 0 && a.hi > a.n - 1) a.hi = a.n - 1;
		a.covered = a.n > 0 && a.lo <= a.hi;
		a.opens = a.covered && a.hi * s == c;
		a.closes = a.covered && a.lo * s + e - 1 == c;
		return a;
	endfunction

	task automatic tally_voxel(bit occ);
		longint unsigned sx, sy, sz, e, s, num;
		axis_span_t ax, ay, az;
		cube_word_t w;
		bit first;
		sx = clamp_reg(reg_val[CFG_SIZE_X]);
		sy = clamp_reg(reg_val[CFG_SIZE_Y]);
		sz = clamp_reg(reg_val[CFG_SIZE_Z]);
		e = clamp_reg(reg_val[CFG_EDGE]);
		s = clamp_reg(reg_val[CFG_STRIDE]);
		ax = span_of(sx, e, s, cur_x);
		ay = span_of(sy, e, s, cur_y);
		az = span_of(sz, e, s, cur_z);
		if (ax.covered && ay.covered && az.covered) begin
			if (occ) begin
				for (longint unsigned iz = az.lo; iz <= az.hi; iz++)
					for (longint unsigned iy = ay.lo; iy <= ay.hi; iy++)
						for (longint unsigned ix = ax.lo; ix <= ax.hi; ix++) begin
							num = (iz * ay.n + iy) * ax.n + ix;
							first = ax.opens && ay.opens && az.opens &&
								iz == az.hi && iy == ay.hi && ix == ax.hi;
							if (first) tally[num % TALLY_N] = 1;
							else tally[num % TALLY_N] = tally[num % TALLY_N] + 1'b1;
						end
			end else if (ax.opens && ay.opens && az.opens) begin
				num = (az.hi * ay.n + ay.hi) * ax.n + ax.hi;
				tally[num % TALLY_N] = '0;
			end
			if (ax.closes && ay.closes && az.closes) begin
				num = (az.lo * ay.n + ay.lo) * ax.n + ax.lo;
				w.cube_number = num[NUM_W-1:0];
				w.start_z = COORD_W'(az.lo * s);
				w.start_y = COORD_W'(ay.lo * s);
				w.start_x = COORD_W'(ax.lo * s);
				w.set_count = tally[num % TALLY_N];
				cube_q = {cube_q, w};
			end
		end
		if (cur_x + 1 >= sx) begin
			cur_x = 0;
			if (cur_y + 1 >= sy) begin
				cur_y = 0;
				if (cur_z + 1 >= sz) cur_z = 0;
				else cur_z++;
			end else begin
				cur_y++;
			end
		end else begin
			cur_x++;
		end
	endtask

	task automatic check_field(string name, longint unsigned exp_v, longint unsigned act_v);
		if (exp_v != act_v) begin
			$error("%s: expected %0d, got %0d", name, exp_v, act_v);
			fail_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		cube_word_t w;
		if (!arst_n) begin
			for (int i = 0; i < CFG_NUM; i++) reg_val[i] = CFG_RESET[i];
			cur_x = 0;
			cur_y = 0;
			cur_z = 0;
			for (int i = 0; i < TALLY_N; i++) tally[i] = '0;
			cube_q.delete();
			fail_count = 0;
			cubes_seen = 0;
		end else begin
			if (cfg_we && cfg_index < CFG_NUM) reg_val[cfg_index] = cfg_data;
			if (in_ch.valid && in_ch.ready) tally_voxel(in_ch.occupied);
			if (out_ch.valid && out_ch.ready) begin
				cubes_seen++;
				if (cube_q.size() == 0) begin
					$error("cube word %0d with no expectation waiting", out_ch.cube_number);
					fail_count++;
				end else begin
					w = cube_q.pop_front();
					check_field("cube_number", w.cube_number, out_ch.cube_number);
					check_field("start_z", w.start_z, out_ch.start_z);
					check_field("start_y", w.start_y, out_ch.start_y);
					check_field("start_x", w.start_x, out_ch.start_x);
					check_field("set_count", w.set_count, out_ch.set_count);
				end
			end
		end
		cubes_pending = cube_q.size();
	end
endmodule

// File: dv/tb_top.sv
// Testbench top: voxel stimulus, result back-pressure and verdict for the cube counter
module tb_top import scoc_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_data;
	int                   fail_count, cubes_pending, cubes_seen;
	int                   send_idle_pct, recv_stall_pct;
	int                   hold_left;
	logic                 hold_req;
	int                   voxels_sent;

	scoc_in_if  in_ch ();
	scoc_out_if out_ch ();

	strided_cube_occupancy_count_unit u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_ch     (in_ch),
		.out_ch    (out_ch)
	);

	scoc_cube_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.in_ch         (in_ch),
		.out_ch        (out_ch),
		.fail_count    (fail_count),
		.cubes_pending (cubes_pending),
		.cubes_seen    (cubes_seen)
	);

	always #5 clk = ~clk;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
			hold_left <= 0;
		end else if (hold_req) begin
			out_ch.ready <= 1'b0;
			hold_left <= 300;
		end else if (hold_left > 0) begin
			out_ch.ready <= 1'b0;
			hold_left <= hold_left - 1;
		end else begin
			out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	initial begin
		#5ms;
		$display("FAIL");
		$finish;
	end

	task automatic send_voxel(bit occ);
		while ($urandom_range(99) < send_idle_pct) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.occupied <= occ;
		do @(posedge clk); while (!in_ch.ready);
		voxels_sent++;
	endtask

	task automatic drain();
		in_ch.valid <= 1'b0;
		@(posedge clk);
		while (cubes_pending != 0) @(posedge clk);
		repeat (600) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic set_volume(int sx, int sy, int sz, int e, int s);
		drain();
		write_reg(CFG_SIZE_X, CFG_W'(sx));
		write_reg(CFG_SIZE_Y, CFG_W'(sy));
		write_reg(CFG_SIZE_Z, CFG_W'(sz));
		write_reg(CFG_EDGE, CFG_W'(e));
		write_reg(CFG_STRIDE, CFG_W'(s));
		@(posedge clk);
	endtask

	task automatic set_idling(int mode);
		case (mode % 4)
			0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
			1: begin send_idle_pct = 51; recv_stall_pct = 0;  end
			2: begin send_idle_pct = 0;  recv_stall_pct = 51; end
			default: begin send_idle_pct = 7; recv_stall_pct = 7; end
		endcase
	endtask

	initial begin
		int sx, sy, sz, e, s, n;
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_ch.valid = 1'b0;
		in_ch.occupied = 1'b0;
		hold_req = 1'b0;
		voxels_sent = 0;
		set_idling(0);
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < 3; i++) send_voxel(1'b1);
		set_volume(2, 2, 2, 2, 1);
		for (int i = 0; i < 8; i++) send_voxel(1'b1);
		set_volume(2, 2, 2, 3, 1);
		for (int i = 0; i < 4; i++) send_voxel(i[0]);
		set_volume(2047, 0, 0, 0, 2047);
		for (int i = 0; i < 6; i++) send_voxel(i[0]);
		set_volume(100, 1, 1, 1, 99);
		for (int i = 0; i < 100; i++) send_voxel(i[1]);
		set_volume(2, 1, 1, 1, 1);
		for (int i = 0; i < 4; i++) send_voxel(i[0]);

		for (int p = 0; p < 9; p++) begin
			sx = $urandom_range(6, 1);
			sy = $urandom_range(6, 1);
			sz = $urandom_range(4, 1);
			e = $urandom_range(3, 1);
			s = $urandom_range(3, 1);
			if (p == 4) begin e = 4; s = 1; sx = 6; sy = 6; sz = 5; end
			if (p == 5) begin e = 1; s = 1; end
			if (p == 7) begin e = 0; s = 0; end
			set_volume(sx, sy, sz, e, s);
			set_idling(p);
			n = 30;
			if (p == 5) begin
				hold_req <= 1'b1;
				@(posedge clk);
				hold_req <= 1'b0;
			end
			for (int i = 0; i < n; i++) send_voxel(p == 6 ? 1'b1 : 1'($urandom_range(1)));
		end
		set_idling(0);
		drain();

		$display("Covered %0d voxels and %0d cube words over directed, extreme and random volumes",
			voxels_sent, cubes_seen);
		if (fail_count == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end
endmodule

// File: sim.f
+incdir+rtl
rtl/scoc_pkg.sv
rtl/scoc_in_if.sv
rtl/scoc_out_if.sv
rtl/scoc_queue.sv
rtl/scoc_front.sv
rtl/scoc_back.sv
rtl/strided_cube_occupancy_count_unit.sv
rtl/scoc_checker.sv
dv/scoc_cube_checker.sv
dv/tb_top.sv
